[rtl/tcs_pkg.sv]
// Shared constants for the text terminal cursor and scroll block.
`timescale 1ns / 1ps

package tcs_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int CELL_W      = 16;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

endpackage

[rtl/tcs_addr_unit.sv]
// Shared address unit: maps a logical row and column to a screen store address.
`timescale 1ns / 1ps

module tcs_addr_unit #(
    parameter int COLUMNS = tcs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcs_pkg::ROWS_DEF,
    parameter int RW      = $clog2(ROWS),
    parameter int CW      = $clog2(COLUMNS + 1),
    parameter int AW      = $clog2(ROWS * COLUMNS)
) (
    input  logic [RW-1:0] row_sel,
    input  logic [CW-1:0] col_sel,
    input  logic [RW-1:0] base,
    output logic [AW-1:0] addr
);

    logic [RW:0]   row_sum;
    logic [RW-1:0] phys_row;

    // The screen is a ring of rows; base is the physical row shown on top.
    always_comb
    begin
        row_sum = {1'b0, row_sel} + {1'b0, base};
        if (row_sum >= (RW + 1)'(ROWS))
        begin
            row_sum = row_sum - (RW + 1)'(ROWS);
        end
        phys_row = row_sum[RW-1:0];
        addr     = AW'(phys_row) * AW'(COLUMNS) + AW'(col_sel);
    end

endmodule

[rtl/tcs_screen_ram.sv]
// Single-port screen store with a registered read.
`timescale 1ns / 1ps

module tcs_screen_ram #(
    parameter int DEPTH = tcs_pkg::ROWS_DEF * tcs_pkg::COLUMNS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic                        rd_en,
    input  logic [AW-1:0]               addr,
    input  logic [tcs_pkg::CELL_W-1:0]  wdata,
    output logic [tcs_pkg::CELL_W-1:0]  rdata
);

    logic [tcs_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

[rtl/text_terminal_cursor_scroll.sv]
// Top level of the character-cell text terminal with cursor and scrolling.
//
// A request is accepted at a rising edge with start high and busy low.
// A put request writes char_code at the cursor in the current color and
// advances the cursor; a newline moves to the next row and stores nothing.
// A read request returns one screen cell; cells off the screen read as 0.
// Each request gives one result on cell_value, cursor_row, cursor_col and
// scrolled, marked by done for exactly one cycle; the receiver cannot stall.
// A read on the screen passes through states ADV, RD and FIN before done, a put
// through ADV, ADDR and FIN, and a newline or a read off the screen through ADV
// and FIN. Scrolling moves the top-of-screen row pointer and then blanks the new
// bottom line one cell per cycle in state SWEEP, before ADDR or FIN. These steps
// share the single store port and the shared address unit.
// After reset the block clears all ROWS * COLUMNS cells to a space in color 0x07
// and holds busy high meanwhile. The text_color register
// is written through cfg_valid and cfg_data; cfg_ready is always high, and
// it should be written only while the block is idle.
`timescale 1ns / 1ps

module text_terminal_cursor_scroll #(
    parameter int COLUMNS = tcs_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcs_pkg::ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [7:0]  char_code,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [15:0] cell_value,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic        scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int AW    = $clog2(CELLS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADV   = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;
    localparam logic [2:0] ST_RD    = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] base_reg, base_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [7:0]    text_color_reg;

    logic          req_reg, req_next;
    logic [7:0]    char_reg, char_next;
    logic [4:0]    rrow_reg, rrow_next;
    logic [6:0]    rcol_reg, rcol_next;
    logic          rd_ok_reg, rd_ok_next;
    logic          scr_reg, scr_next;

    logic [AW-1:0] addr_reg, addr_next;
    logic          we_reg, we_next;
    logic [15:0]   wdata_reg, wdata_next;
    logic          rd_en;
    logic [15:0]   rdata;

    logic          done_reg;
    logic [15:0]   cell_reg;
    logic [4:0]    orow_reg;
    logic [6:0]    ocol_reg;
    logic          oscr_reg;

    logic [RW-1:0] row_sel;
    logic [CW-1:0] col_sel;
    logic [AW-1:0] unit_addr;
    logic          is_nl;
    logic          wrap;
    logic [RW:0]   row_inc;
    logic          in_range;

    tcs_addr_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .RW      (RW),
        .CW      (CW),
        .AW      (AW)
    ) u_addr (
        .row_sel (row_sel),
        .col_sel (col_sel),
        .base    (base_reg),
        .addr    (unit_addr)
    );

    tcs_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we_reg),
        .rd_en (rd_en),
        .addr  (addr_reg),
        .wdata (wdata_reg),
        .rdata (rdata)
    );

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign rd_en      = (state_reg == ST_RD);
    assign done       = done_reg;
    assign cell_value = cell_reg;
    assign cursor_row = orow_reg;
    assign cursor_col = ocol_reg;
    assign scrolled   = oscr_reg;

    assign is_nl    = (char_reg == tcs_pkg::NEWLINE_CODE);
    assign wrap     = (col_reg >= CW'(COLUMNS)) || is_nl;
    assign row_inc  = {1'b0, row_reg} + (RW + 1)'(1);
    assign in_range = (32'(rrow_reg) < 32'(ROWS)) && (32'(rcol_reg) < 32'(COLUMNS));

    always_comb
    begin
        unique case (state_reg)
            ST_ADV:
            begin
                row_sel = RW'(rrow_reg);
                col_sel = CW'(rcol_reg);
            end
            ST_SWEEP:
            begin
                row_sel = RW'(ROWS - 1);
                col_sel = cnt_reg;
            end
            default:
            begin
                row_sel = row_reg;
                col_sel = col_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        req_next   = req_reg;
        char_next  = char_reg;
        rrow_next  = rrow_reg;
        rcol_next  = rcol_reg;
        rd_ok_next = rd_ok_reg;
        scr_next   = scr_reg;
        addr_next  = addr_reg;
        we_next    = 1'b0;
        wdata_next = wdata_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                addr_next  = clr_reg;
                we_next    = 1'b1;
                wdata_next = {tcs_pkg::RESET_COLOR, tcs_pkg::SPACE_CODE};
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    char_next  = char_code;
                    rrow_next  = read_row;
                    rcol_next  = read_col;
                    scr_next   = 1'b0;
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (req_reg == tcs_pkg::REQ_READ)
                begin
                    rd_ok_next = in_range;
                    addr_next  = unit_addr;
                    state_next = in_range ? ST_RD : ST_FIN;
                end
                else
                begin
                    rd_ok_next = 1'b0;
                    state_next = is_nl ? ST_FIN : ST_ADDR;
                    if (wrap)
                    begin
                        col_next = '0;
                        if (row_inc >= (RW + 1)'(ROWS))
                        begin
                            row_next   = RW'(ROWS - 1);
                            base_next  = (base_reg == RW'(ROWS - 1)) ? '0 : base_reg + RW'(1);
                            cnt_next   = '0;
                            scr_next   = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        else
                        begin
                            row_next = row_inc[RW-1:0];
                        end
                    end
                end
            end
            ST_SWEEP:
            begin
                addr_next  = unit_addr;
                we_next    = 1'b1;
                wdata_next = {text_color_reg, tcs_pkg::SPACE_CODE};
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(COLUMNS - 1))
                begin
                    state_next = is_nl ? ST_FIN : ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                addr_next  = unit_addr;
                we_next    = 1'b1;
                wdata_next = {text_color_reg, char_reg};
                col_next   = col_reg + CW'(1);
                state_next = ST_FIN;
            end
            ST_RD:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            row_reg        <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            cnt_reg        <= '0;
            clr_reg        <= '0;
            we_reg         <= 1'b0;
            done_reg       <= 1'b0;
            text_color_reg <= tcs_pkg::RESET_COLOR;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            we_reg    <= we_next;
            done_reg  <= (state_reg == ST_FIN);
            if (cfg_valid && cfg_ready)
            begin
                text_color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        char_reg  <= char_next;
        rrow_reg  <= rrow_next;
        rcol_reg  <= rcol_next;
        rd_ok_reg <= rd_ok_next;
        scr_reg   <= scr_next;
        addr_reg  <= addr_next;
        wdata_reg <= wdata_next;
        if (state_reg == ST_FIN)
        begin
            cell_reg <= rd_ok_reg ? rdata : 16'd0;
            orow_reg <= 5'(row_reg);
            ocol_reg <= 7'(col_reg);
            oscr_reg <= scr_reg;
        end
    end

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Block did not turn busy after an accepted item.");

    a_scroll_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (cursor_row == 5'(ROWS - 1) && cursor_col <= 7'(1)))
        else $error("Scroll left the cursor away from the bottom row.");

    a_no_write_when_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> (state_reg == ST_IDLE || state_reg == ST_ADV))
        else $error("Idle sequencer jumped past request decode.");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench for the text terminal with cursor, deferred wrap and scrolling.
`timescale 1ns / 1ps

module testbench;

    localparam int COLS = tcs_pkg::COLUMNS_DEF;
    localparam int ROWS = tcs_pkg::ROWS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_COUNT = 7;
    localparam int PHASE_ITEMS = 147;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } terminal_result_t;

    class terminal_scoreboard;
        bit [15:0] screen [ROWS * COLS];
        int unsigned row_now;
        int unsigned col_now;
        bit [7:0] color;
        terminal_result_t expected_q [$];
        int failures;

        function new();
            foreach (screen[i])
            begin
                screen[i] = {tcs_pkg::RESET_COLOR, tcs_pkg::SPACE_CODE};
            end
            row_now = 0;
            col_now = 0;
            color = tcs_pkg::RESET_COLOR;
            failures = 0;
        endfunction

        function void set_color(bit [7:0] value);
            color = value;
        endfunction

        function void note_request(logic req, logic [7:0] ch, logic [4:0] rrow,
                                   logic [6:0] rcol);
            terminal_result_t want;
            bit is_newline;
            want = '0;
            if (req == tcs_pkg::REQ_READ)
            begin
                if (rrow < ROWS && rcol < COLS)
                begin
                    want.cell_value = screen[rrow * COLS + rcol];
                end
            end
            else
            begin
                is_newline = (ch == tcs_pkg::NEWLINE_CODE);
                if (col_now >= COLS || is_newline)
                begin
                    row_now++;
                    col_now = 0;
                    if (row_now >= ROWS)
                    begin
                        for (int i = 0; i < (ROWS - 1) * COLS; i++)
                        begin
                            screen[i] = screen[i + COLS];
                        end
                        for (int c = 0; c < COLS; c++)
                        begin
                            screen[(ROWS - 1) * COLS + c] = {color, tcs_pkg::SPACE_CODE};
                        end
                        want.scrolled = 1'b1;
                        row_now = ROWS - 1;
                    end
                end
                if (!is_newline)
                begin
                    screen[row_now * COLS + col_now] = {color, ch};
                    col_now++;
                end
            end
            want.cursor_row = row_now[4:0];
            want.cursor_col = col_now[6:0];
            expected_q.push_back(want);
        endfunction

        function void check_result(terminal_result_t got);
            terminal_result_t want;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("Unexpected result: %p", got);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.cell_value !== want.cell_value || got.cursor_row !== want.cursor_row ||
                got.cursor_col !== want.cursor_col || got.scrolled !== want.scrolled)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("Mismatch: cell %h/%h row %0d/%0d col %0d/%0d scrolled %0d/%0d",
                             want.cell_value, got.cell_value, want.cursor_row, got.cursor_row,
                             want.cursor_col, got.cursor_col, want.scrolled, got.scrolled);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [7:0]  char_code;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        done;
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;

    terminal_scoreboard board = new();
    int stall_cycles = 0;

    text_terminal_cursor_scroll i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .cell_value (cell_value),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            board.check_result({cell_value, cursor_row, cursor_col, scrolled});
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    task automatic send_request(logic req, logic [7:0] ch, logic [4:0] rrow, logic [6:0] rcol);
        start     <= 1'b1;
        req_type  <= req;
        char_code <= ch;
        read_row  <= rrow;
        read_col  <= rcol;
        do @(posedge clk); while (busy);
        board.note_request(req, ch, rrow, rcol);
    endtask

    task automatic idle_gap(int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_color(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_color(value);
        @(posedge clk);
    endtask

    task automatic random_request(int newline_pct, int idle_pct);
        logic [7:0] ch;
        logic [4:0] rrow;
        logic [6:0] rcol;
        int pick;
        ch   = 8'($urandom_range(255));
        rrow = 5'($urandom_range(31));
        rcol = 7'($urandom_range(127));
        idle_gap(idle_pct);
        if ($urandom_range(99) < 25)
        begin
            pick = int'($urandom_range(99));
            if (pick < 60)
            begin
                rrow = 5'($urandom_range(ROWS - 1));
                rcol = 7'($urandom_range(COLS - 1));
            end
            else if (pick < 80)
            begin
                rrow = 5'(board.row_now);
                rcol = 7'($urandom_range(COLS - 1));
            end
            send_request(tcs_pkg::REQ_READ, ch, rrow, rcol);
        end
        else
        begin
            if (board.col_now >= COLS)
            begin
                if ($urandom_range(99) < 35)
                begin
                    ch = tcs_pkg::NEWLINE_CODE;
                end
            end
            else if ($urandom_range(99) < newline_pct)
            begin
                ch = tcs_pkg::NEWLINE_CODE;
            end
            send_request(tcs_pkg::REQ_PUT, ch, rrow, rcol);
        end
    endtask

    initial
    begin
        int newline_pct [PHASE_COUNT];
        int idle_pct    [PHASE_COUNT];
        logic [7:0] colors [PHASE_COUNT];
        newline_pct = '{2, 8, 1, 20, 5, 0, 12};
        idle_pct    = '{23, 23, 0, 23, 23, 23, 23};
        colors = '{tcs_pkg::RESET_COLOR, 8'hFF, 8'h00, 8'h00, 8'hFF,
                   tcs_pkg::RESET_COLOR, 8'h00};
        colors[3] = 8'($urandom_range(255));
        colors[6] = 8'($urandom_range(255));
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req_type  <= tcs_pkg::REQ_PUT;
        char_code <= 8'h00;
        read_row  <= 5'd0;
        read_col  <= 7'd0;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Cleared screen, far corners and off-screen reads, then puts and readback.
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_READ, 8'hFF, 5'd24, 7'd79);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd25, 7'd0);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd0, 7'd80);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd31, 7'd127);
        send_request(tcs_pkg::REQ_PUT, 8'h00, 5'd31, 7'd127);
        send_request(tcs_pkg::REQ_PUT, 8'hFF, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_PUT, 8'h09, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_PUT, 8'h0B, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_PUT, tcs_pkg::NEWLINE_CODE, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_PUT, tcs_pkg::NEWLINE_CODE, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_PUT, tcs_pkg::SPACE_CODE, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_PUT, 8'h41, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd0, 7'd1);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd0, 7'd3);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd0, 7'd4);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd1, 7'd0);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd2, 7'd1);
        send_request(tcs_pkg::REQ_READ, 8'h00, 5'd2, 7'd2);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                write_color(colors[p]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_request(newline_pct[p], idle_pct[p]);
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
